### rtl/core/avm_pkg.sv
// shared types, constants and the segment table for the voltmeter display driver
package avm_pkg;

  localparam int DIGIT_COUNT  = 3;
  localparam int INDEX_W      = 2;
  localparam int SAMPLE_W     = 16;
  localparam int SCALE_W      = 10;
  localparam int DP_MASK_W    = 3;
  localparam int PROD_W       = SAMPLE_W + SCALE_W;
  localparam int READING_W    = 10;
  localparam int TENS_W       = 7;
  localparam int BCD_W        = 4;
  localparam int FRONT_STAGES = 4;
  localparam int QUEUE_DEPTH  = 8;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W        = $clog2(QUEUE_DEPTH + FRONT_STAGES + 1);
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 10;

  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DP_MASK = 2'd1;

  localparam logic [SCALE_W-1:0]   SCALE_RESET   = 10'd330;
  localparam logic [DP_MASK_W-1:0] DP_MASK_RESET = 3'd4;

  typedef struct packed {
    logic [SAMPLE_W-1:0] adc_sample;
    logic                tick;
  } in_item_t;

  typedef struct packed {
    logic [7:0] segment_lines;
    logic [2:0] digit_enables;
    logic       display_lit;
  } out_item_t;

  typedef struct packed {
    logic             tick;
    logic [BCD_W-1:0] hundreds;
    logic [BCD_W-1:0] tens;
    logic [BCD_W-1:0] ones;
  } digits_t;

  typedef struct packed {
    logic [SCALE_W-1:0]   scale_factor;
    logic [DP_MASK_W-1:0] decimal_point_mask;
  } cfg_t;

  function automatic logic [7:0] seg_pattern(input logic [BCD_W-1:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'hc0;
      4'd1:    seg = 8'hf9;
      4'd2:    seg = 8'h24;
      4'd3:    seg = 8'h30;
      4'd4:    seg = 8'h19;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h02;
      4'd7:    seg = 8'hf8;
      4'd8:    seg = 8'h00;
      4'd9:    seg = 8'h98;
      default: seg = 8'hff;
    endcase
    return seg;
  endfunction

endpackage

### rtl/core/avm_front.sv
// front pipeline: accepts samples, scales them and splits the reading into decimal digits
module avm_front import avm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  input  logic [SCALE_W-1:0]  scale_factor,
  input  logic [QCOUNT_W-1:0] q_count,
  output logic                push,
  output digits_t             push_data
);

  logic                 s1_valid, s2_valid, s3_valid, s4_valid;
  logic                 s1_tick, s2_tick, s3_tick;
  logic [PROD_W-1:0]    s1_product;
  logic [READING_W-1:0] s2_reading;
  logic [READING_W-1:0] s3_reading;
  logic [TENS_W-1:0]    s3_tens_all;
  logic [BCD_W-1:0]     s3_hundreds;
  digits_t              s4_digits;

  logic [OCC_W-1:0]     occupancy;
  logic                 accept;
  logic [PROD_W-1:0]    div_sum;
  logic [READING_W-1:0] quotient;
  logic [READING_W-1:0] reading_mod;
  logic [17:0]          tens_prod;
  logic [15:0]          hund_prod;
  logic [READING_W-1:0] ones_diff;
  logic [TENS_W-1:0]    tens_diff;

  assign occupancy = OCC_W'(s1_valid) + OCC_W'(s2_valid) + OCC_W'(s3_valid)
                   + OCC_W'(s4_valid) + OCC_W'(q_count);
  assign in_stall  = (occupancy >= OCC_W'(QUEUE_DEPTH));
  assign accept    = in_valid && !in_stall;

  // divide by 65535
  assign div_sum     = s1_product + PROD_W'(s1_product[PROD_W-1:16]) + PROD_W'(1);
  assign quotient    = div_sum[PROD_W-1:16];
  assign reading_mod = (quotient >= READING_W'(1000)) ? quotient - READING_W'(1000) : quotient;

  // reading / 10 and reading / 100 by reciprocal
  assign tens_prod = 18'(s2_reading) * 18'd205;
  assign hund_prod = 16'(s2_reading) * 16'd41;

  assign ones_diff = s3_reading - {s3_tens_all, 3'b000} - READING_W'({s3_tens_all, 1'b0});
  assign tens_diff = s3_tens_all - TENS_W'({s3_hundreds, 3'b000})
                   - TENS_W'({s3_hundreds, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_product         <= PROD_W'(in_data.adc_sample) * PROD_W'(scale_factor);
    s1_tick            <= in_data.tick;
    s2_reading         <= reading_mod;
    s2_tick            <= s1_tick;
    s3_reading         <= s2_reading;
    s3_tens_all        <= tens_prod[17:11];
    s3_hundreds        <= hund_prod[15:12];
    s3_tick            <= s2_tick;
    s4_digits.tick     <= s3_tick;
    s4_digits.hundreds <= s3_hundreds;
    s4_digits.tens     <= tens_diff[BCD_W-1:0];
    s4_digits.ones     <= ones_diff[BCD_W-1:0];
  end

  assign push      = s4_valid;
  assign push_data = s4_digits;

endmodule

### rtl/core/avm_queue.sv
// short fifo of digit beats between the front pipeline and the display sequencer
module avm_queue import avm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  digits_t             push_data,
  input  logic                pop,
  output digits_t             head,
  output logic                not_empty,
  output logic [QCOUNT_W-1:0] count
);

  // head register in front of the array, the array holds the beats behind it
  digits_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              head_valid;
  logic              take;
  logic              mem_empty;
  logic              mem_rd;
  logic              mem_wr;

  // at most seven beats sit behind the head, so equal pointers mean empty
  assign take      = !head_valid || pop;
  assign mem_empty = (wr_ptr == rd_ptr);
  assign mem_rd    = take && !mem_empty;
  assign mem_wr    = push && !(take && mem_empty);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
      head_valid <= 1'b0;
    end else begin
      if (mem_wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (mem_rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (take) begin
        head_valid <= !mem_empty || push;
      end
      if (push && !pop) begin
        count <= count + QCOUNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCOUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      entries[wr_ptr] <= push_data;
    end
    if (mem_rd) begin
      head <= entries[rd_ptr];
    end else if (take && push) begin
      head <= push_data;
    end
  end

  assign not_empty = head_valid;

endmodule

### rtl/core/avm_back.sv
// back end: blank/lit phase sequencer, digit scan and the output port image register
module avm_back import avm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_not_empty,
  input  digits_t              q_head,
  output logic                 pop,
  input  logic [DP_MASK_W-1:0] dp_mask,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  typedef enum logic [1:0] {
    PH_BLANK = 2'b01,
    PH_LIT   = 2'b10
  } phase_t;

  phase_t             phase, phase_next;
  logic [INDEX_W-1:0] digit_index, digit_index_next;
  out_item_t          image_next;

  logic [1:0]         en_pos;
  logic [BCD_W-1:0]   digit_val;
  logic [7:0]         seg;
  logic [INDEX_W:0]   index_inc;

  assign pop = q_not_empty && (!out_valid || !out_stall);

  assign en_pos    = (digit_index == 2'd3) ? 2'd0 : digit_index;
  assign index_inc = {1'b0, digit_index} + (INDEX_W + 1)'(1);

  always_comb begin
    case (digit_index)
      2'd0:    digit_val = q_head.ones;
      2'd1:    digit_val = q_head.tens;
      default: digit_val = q_head.hundreds;
    endcase
  end

  always_comb begin
    seg    = seg_pattern(digit_val);
    seg[7] = !dp_mask[en_pos];
  end

  always_comb begin
    phase_next       = phase;
    digit_index_next = digit_index;
    image_next       = out_data;
    if (q_head.tick) begin
      unique case (phase)
        PH_LIT: begin
          phase_next       = PH_BLANK;
          image_next       = '0;
          digit_index_next = (index_inc >= (INDEX_W + 1)'(DIGIT_COUNT)) ? '0
                                                                      : index_inc[INDEX_W-1:0];
        end
        PH_BLANK: begin
          phase_next                 = PH_LIT;
          image_next.segment_lines   = seg;
          image_next.digit_enables   = 3'b001 << en_pos;
          image_next.display_lit     = 1'b1;
        end
        default: begin
          phase_next = PH_BLANK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_BLANK;
      digit_index <= '0;
      out_data    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        phase       <= phase_next;
        digit_index <= digit_index_next;
        out_data    <= image_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/adc_voltmeter_seven_segment_mux.sv
// top level of the three-digit multiplexed seven-segment voltmeter driver
// Takes one sample beat per clock while in_stall is low and returns one port-image beat for
// each, in order. A beat passes through the front pipeline (16x10 multiply, divide by 65535
// with reduction modulo 1000, two reciprocal multiplies, digit split), then waits in an
// eight-entry queue for the phase sequencer, which registers the result. in_stall rises once
// eight beats are in the front pipeline and queue together. Configuration writes are always
// ready and are registered before use.
module adc_voltmeter_seven_segment_mux import avm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t                cfg;
  logic                push;
  digits_t             push_data;
  logic                pop;
  digits_t             q_head;
  logic                q_not_empty;
  logic [QCOUNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_factor       <= SCALE_RESET;
      cfg.decimal_point_mask <= DP_MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCALE:   cfg.scale_factor       <= cfg_data[SCALE_W-1:0];
        CFG_DP_MASK: cfg.decimal_point_mask <= cfg_data[DP_MASK_W-1:0];
        default: ;
      endcase
    end
  end

  avm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .scale_factor (cfg.scale_factor),
    .q_count      (q_count),
    .push         (push),
    .push_data    (push_data)
  );

  avm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  avm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .dp_mask     (cfg.decimal_point_mask),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCOUNT_W'(QUEUE_DEPTH))
    else $error("queue overflow");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> q_count < QCOUNT_W'(QUEUE_DEPTH))
    else $error("push into full queue");

  a_lit_matches_enable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(out_data.digit_enables)
                  && (out_data.display_lit == (out_data.digit_enables != 3'd0)))
    else $error("digit enables disagree with phase");

  a_blank_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.display_lit |-> out_data.segment_lines == 8'd0)
    else $error("segments driven in blank phase");

endmodule
